/* design/les_pkg.sv */
// ----------------------------------------------------------------------------
// les_pkg
// Shared widths, register indexes, reset values, the configuration bundle
// and the three-way minimum of the largest empty square finder.
// ----------------------------------------------------------------------------
package les_pkg;

  // Field widths of the request and result channels.
  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 11;
  localparam int POS_W     = 10;
  localparam int CFG_LEN_W = 11;

  // Register port geometry: three 32-bit registers at byte addresses 0, 4, 8.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int IDX_W  = 2;

  // Register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_OBSTACLE_CHAR = 2'd0,
    REG_ROW_LENGTH    = 2'd1,
    REG_ROW_COUNT     = 2'd2
  } les_reg_idx_t;

  // Reset values of the registers.
  localparam logic [BYTE_W-1:0]    OBSTACLE_RST   = 8'd111;
  localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [CFG_LEN_W-1:0] ROW_COUNT_RST  = 11'd1024;

  // Effective configuration seen by the scan datapath (lengths clamped).
  typedef struct packed {
    logic [BYTE_W-1:0]    obstacle_char;
    logic [CFG_LEN_W-1:0] cols;
    logic [CFG_LEN_W-1:0] rows;
  } les_cfg_t;

  // Smallest of three square sizes.
  function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                             input logic [SIZE_W-1:0] b,
                                             input logic [SIZE_W-1:0] c);
    logic [SIZE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

/* design/largest_empty_square_finder.sv */
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// The result of a map passes the compute stage and then the result register.
// Throughput: one cell per cycle; each cell costs one line-store read and one
// write, and the line store's single read and write ports set that figure.
// Input stalls only while a finished result waits and the next map end is due.
// Reset: synchronous, clears the scan position, best square and registers;
// the line store is not cleared (entries are written before being read).
// ----------------------------------------------------------------------------
module largest_empty_square_finder #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Cell requests.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [les_pkg::BYTE_W-1:0]    in_cell_byte,
  // Result requests.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [les_pkg::SIZE_W-1:0]    out_best_size,
  output logic [les_pkg::POS_W-1:0]     out_top_row,
  output logic [les_pkg::POS_W-1:0]     out_left_col,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [les_pkg::ADDR_W-1:0]    paddr,
  input  logic [les_pkg::DATA_W-1:0]    pwdata,
  output logic [les_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import les_pkg::*;

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ECW = ((CW > CFG_LEN_W) ? CW : CFG_LEN_W) + 1;
  localparam int ERW = ((RW > CFG_LEN_W) ? RW : CFG_LEN_W) + 1;
  localparam int TCW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
  localparam int TRW = ((RW > SIZE_W) ? RW : SIZE_W) + 1;

  les_cfg_t cfg;

  // Scan position of the next accepted cell.
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          last_col;
  logic          last_row;

  // Compute stage: one cell with its line-store read data.
  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_col0_r;
  logic          s1_row0_r;
  logic          s1_obst_r;
  logic          s1_last_r;
  logic          s1_fwd_r;

  // Running sizes and best square.
  logic [SIZE_W-1:0] left_size_r;
  logic [SIZE_W-1:0] diag_size_r;
  logic [SIZE_W-1:0] best_side_r;
  logic [RW-1:0]     best_bot_r;
  logic [CW-1:0]     best_right_r;

  logic [SIZE_W-1:0] best_side_nxt;
  logic [RW-1:0]     best_bot_nxt;
  logic [CW-1:0]     best_right_nxt;

  // Result register.
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [POS_W-1:0]  out_top_r;
  logic [POS_W-1:0]  out_left_r;

  logic              in_acc;
  logic              stall;
  logic              s1_adv;
  logic [SIZE_W-1:0] ram_rdata;
  logic [SIZE_W-1:0] above;
  logic [SIZE_W-1:0] diag;
  logic [SIZE_W-1:0] left;
  logic [SIZE_W-1:0] size;
  logic [TRW-1:0]    top_wide;
  logic [TCW-1:0]    left_wide;
  logic [POS_W-1:0]  top_pos;
  logic [POS_W-1:0]  left_pos;

  les_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the pipeline only holds when a map end meets a waiting result.
  assign stall    = s1_valid_r && s1_last_r && out_valid_r && !out_ready;
  assign in_ready = !stall;
  assign in_acc   = in_valid && in_ready;
  assign s1_adv   = s1_valid_r && !stall;

  // Row and map end detection against the clamped dimensions.
  assign last_col = (ECW'(col_r) + ECW'(1)) >= ECW'(cfg.cols);
  assign last_row = (ERW'(row_r) + ERW'(1)) >= ERW'(cfg.rows);

  // Line store of the sizes in the row above.
  les_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (size),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Cell size from its three neighbors; a one-cell row forwards the size
  // just written, which the line store cannot yet return.
  always_comb begin
    above = s1_row0_r ? '0 : (s1_fwd_r ? left_size_r : ram_rdata);
    diag  = (s1_row0_r || s1_col0_r) ? '0 : diag_size_r;
    left  = s1_col0_r ? '0 : left_size_r;
    size  = s1_obst_r ? '0 : (min3(above, diag, left) + SIZE_W'(1));
  end

  // Best square including the current cell; strictly larger wins.
  always_comb begin
    if (size > best_side_r) begin
      best_side_nxt  = size;
      best_bot_nxt   = s1_row_r;
      best_right_nxt = s1_col_r;
    end else begin
      best_side_nxt  = best_side_r;
      best_bot_nxt   = best_bot_r;
      best_right_nxt = best_right_r;
    end
    top_wide  = TRW'(best_bot_nxt) + TRW'(1) - TRW'(best_side_nxt);
    left_wide = TCW'(best_right_nxt) + TCW'(1) - TCW'(best_side_nxt);
    top_pos   = (best_side_nxt == '0) ? '0 : top_wide[POS_W-1:0];
    left_pos  = (best_side_nxt == '0) ? '0 : left_wide[POS_W-1:0];
  end

  // Scan position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : (row_r + RW'(1));
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Compute stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= in_acc;
    end
  end

  // Compute stage payload, loaded with the line-store read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_col0_r <= (col_r == '0);
      s1_row0_r <= (row_r == '0);
      s1_obst_r <= (in_cell_byte == cfg.obstacle_char);
      s1_last_r <= last_col && last_row;
      s1_fwd_r  <= s1_valid_r && (s1_col_r == col_r);
    end
  end

  // Neighbor sizes and best square, updated as each cell completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_size_r  <= '0;
      diag_size_r  <= '0;
      best_side_r  <= '0;
      best_bot_r   <= '0;
      best_right_r <= '0;
    end else if (s1_adv) begin
      left_size_r <= size;
      diag_size_r <= above;
      if (s1_last_r) begin
        best_side_r  <= '0;
        best_bot_r   <= '0;
        best_right_r <= '0;
      end else begin
        best_side_r  <= best_side_nxt;
        best_bot_r   <= best_bot_nxt;
        best_right_r <= best_right_nxt;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload at the end of each map.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_size_r <= best_side_nxt;
      out_top_r  <= top_pos;
      out_left_r <= left_pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_size = out_size_r;
  assign out_top_row   = out_top_r;
  assign out_left_col  = out_left_r;

endmodule

/* design/les_ram.sv */
// ----------------------------------------------------------------------------
// les_ram
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module les_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/les_cfg.sv */
// ----------------------------------------------------------------------------
// les_cfg
// APB-style register file for the obstacle byte and the map dimensions.
// Presents the dimensions clamped to the supported range.
// ----------------------------------------------------------------------------
module les_cfg #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [les_pkg::ADDR_W-1:0]    paddr,
  input  logic [les_pkg::DATA_W-1:0]    pwdata,
  output logic [les_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output les_pkg::les_cfg_t             cfg
);

  import les_pkg::*;

  localparam logic [CFG_LEN_W-1:0] MAX_COLS_L = CFG_LEN_W'(MAX_COLS);
  localparam logic [CFG_LEN_W-1:0] MAX_ROWS_L = CFG_LEN_W'(MAX_ROWS);

  logic [BYTE_W-1:0]    obstacle_r;
  logic [CFG_LEN_W-1:0] row_length_r;
  logic [CFG_LEN_W-1:0] row_count_r;
  les_reg_idx_t         reg_idx;
  logic                 wr_en;

  assign reg_idx = les_reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes; the unused index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r   <= OBSTACLE_RST;
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OBSTACLE_CHAR: obstacle_r   <= pwdata[BYTE_W-1:0];
        REG_ROW_LENGTH:    row_length_r <= pwdata[CFG_LEN_W-1:0];
        REG_ROW_COUNT:     row_count_r  <= pwdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the raw register values.
  always_comb begin
    unique case (reg_idx)
      REG_OBSTACLE_CHAR: prdata = DATA_W'(obstacle_r);
      REG_ROW_LENGTH:    prdata = DATA_W'(row_length_r);
      REG_ROW_COUNT:     prdata = DATA_W'(row_count_r);
      default:           prdata = '0;
    endcase
  end

  // A length of zero acts as one, and a length above the maximum as the maximum.
  always_comb begin
    cfg.obstacle_char = obstacle_r;
    if (row_length_r == '0) begin
      cfg.cols = CFG_LEN_W'(1);
    end else if (32'(row_length_r) > MAX_COLS) begin
      cfg.cols = MAX_COLS_L;
    end else begin
      cfg.cols = row_length_r;
    end
    if (row_count_r == '0) begin
      cfg.rows = CFG_LEN_W'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      cfg.rows = MAX_ROWS_L;
    end else begin
      cfg.rows = row_count_r;
    end
  end

endmodule

/* design/les_checker.sv */
// ----------------------------------------------------------------------------
// les_checker
// Port-level checks of the largest empty square finder, bound to the top.
// ----------------------------------------------------------------------------
module les_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [les_pkg::SIZE_W-1:0]    out_best_size,
  input logic [les_pkg::POS_W-1:0]     out_top_row,
  input logic [les_pkg::POS_W-1:0]     out_left_col
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_size) &&
      $stable(out_top_row) && $stable(out_left_col))
    else $error("result changed while stalled");

  // Cell requests are refused only while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a waiting result");

  // Reset leaves no result offered.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // An all-obstacle map reports the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_best_size == '0 |-> out_top_row == '0 && out_left_col == '0)
    else $error("empty result with nonzero corner");

  // The reported square lies inside the map.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (12'(out_top_row) + 12'(out_best_size)) <= 12'd1024 &&
      (12'(out_left_col) + 12'(out_best_size)) <= 12'd1024)
    else $error("reported square leaves the map");

endmodule

bind largest_empty_square_finder les_checker u_les_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams character maps into the largest empty square finder and checks
// every reported square against a cycle-free predictor kept in step with the
// accepted cells. Register settings change only between maps, while both
// request channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import les_pkg::*;

  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 4;
  localparam int LINE_DEPTH        = 1024;
  localparam int MAP_ROWS_MAX      = 1024;
  localparam int CYCLE_LIMIT       = 200000;
  localparam int SMALL_CELL_BUDGET = 280;
  localparam int LONG_HOLD         = 300;
  localparam int IDLE_GUARD        = 4;
  localparam int END_DRAIN         = 10;
  localparam int MAX_WAIT          = 4;

  // Index with no register behind it; writes there must be ignored.
  localparam logic [IDX_W-1:0] UNUSED_REG_IDX = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } square_t;

  // Clock, reset and block ports.
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_cell_byte = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [SIZE_W-1:0] out_best_size;
  logic [POS_W-1:0]  out_top_row;
  logic [POS_W-1:0]  out_left_col;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Handshake bookkeeping shared between the driver, sink and checker.
  logic [BYTE_W-1:0] pending_cells[$];
  logic              cell_taken      = 1'b0;
  logic              result_taken    = 1'b0;
  logic              send_idle_en    = 1'b1;
  logic              recv_idle_en    = 1'b1;
  logic              long_hold_req   = 1'b0;
  logic              long_hold_begun = 1'b0;
  int                send_wait       = 0;
  int                recv_wait       = 0;
  int                hold_left       = 0;

  // Counters for progress and the summary.
  int cycle_count     = 0;
  int cells_queued    = 0;
  int cells_accepted  = 0;
  int squares_checked = 0;
  int settings_used   = 0;
  int mismatches      = 0;

  // Predictor state: configuration copy, line of running sizes, scan position.
  logic [BYTE_W-1:0]    obstacle_byte  = OBSTACLE_RST;
  logic [CFG_LEN_W-1:0] row_length_reg = ROW_LENGTH_RST;
  logic [CFG_LEN_W-1:0] row_count_reg  = ROW_COUNT_RST;
  logic [SIZE_W-1:0]    line_sizes[LINE_DEPTH];
  int                   scan_col       = 0;
  int                   scan_row       = 0;
  int                   left_run       = 0;
  int                   diag_run       = 0;
  int                   best_side      = 0;
  int                   best_row       = 0;
  int                   best_col       = 0;
  square_t              expected_squares[$];

  largest_empty_square_finder #(
    .MAX_COLS(LINE_DEPTH),
    .MAX_ROWS(MAP_ROWS_MAX)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cell_byte (in_cell_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_best_size(out_best_size),
    .out_top_row  (out_top_row),
    .out_left_col (out_left_col),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #CLK_HALF clk = ~clk;

  // A length of zero acts as one, and anything above the maximum as the maximum.
  function automatic int clamp_length(input int value, input int limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  task automatic clear_scan();
    scan_col  = 0;
    scan_row  = 0;
    left_run  = 0;
    diag_run  = 0;
    best_side = 0;
    best_row  = 0;
    best_col  = 0;
  endtask

  // Advances the predicted scan by one cell and queues the square at a map end.
  task automatic scan_cell(input logic [BYTE_W-1:0] cell_byte);
    int      cols;
    int      rows;
    int      above;
    int      diag;
    int      left;
    int      side;
    square_t found;
    cols  = clamp_length(int'(row_length_reg), LINE_DEPTH);
    rows  = clamp_length(int'(row_count_reg), MAP_ROWS_MAX);
    above = (scan_row == 0) ? 0 : int'(line_sizes[scan_col]);
    diag  = (scan_row == 0 || scan_col == 0) ? 0 : diag_run;
    left  = (scan_col == 0) ? 0 : left_run;
    if (cell_byte == obstacle_byte) begin
      side = 0;
    end else begin
      side = (above < diag) ? above : diag;
      if (left < side) side = left;
      side = (side + 1) % (1 << SIZE_W);
    end
    diag_run             = above;
    line_sizes[scan_col] = SIZE_W'(side);
    left_run             = side;

    // Only a strictly larger square moves the best one, so ties keep the first.
    if (side > best_side) begin
      best_side = side;
      best_row  = scan_row;
      best_col  = scan_col;
    end

    if (scan_col + 1 >= cols) begin
      scan_col = 0;
      if (scan_row + 1 >= rows) begin
        found.size = SIZE_W'(best_side);
        found.row  = (best_side == 0) ? '0 : POS_W'(best_row + 1 - best_side);
        found.col  = (best_side == 0) ? '0 : POS_W'(best_col + 1 - best_side);
        expected_squares.push_back(found);
        clear_scan();
      end else begin
        scan_row++;
      end
    end else begin
      scan_col++;
    end
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [IDX_W-1:0] index,
                                input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(index) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_OBSTACLE_CHAR: obstacle_byte  = value[BYTE_W-1:0];
      REG_ROW_LENGTH:    row_length_reg = value[CFG_LEN_W-1:0];
      REG_ROW_COUNT:     row_count_reg  = value[CFG_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int obstacle, input int length, input int count);
    write_register(REG_OBSTACLE_CHAR, obstacle);
    write_register(REG_ROW_LENGTH, length);
    write_register(REG_ROW_COUNT, count);
    settings_used++;
  endtask

  // Queues one whole map; density is the chance in percent of an obstacle.
  task automatic queue_map(input int density);
    int                cols;
    int                rows;
    logic [BYTE_W-1:0] cell_byte;
    cols = clamp_length(int'(row_length_reg), LINE_DEPTH);
    rows = clamp_length(int'(row_count_reg), MAP_ROWS_MAX);
    repeat (cols * rows) begin
      if ($urandom_range(0, 99) < density) begin
        cell_byte = obstacle_byte;
      end else begin
        cell_byte = BYTE_W'($urandom_range(0, 255));
        while (cell_byte == obstacle_byte) cell_byte = BYTE_W'($urandom_range(0, 255));
      end
      pending_cells.push_back(cell_byte);
    end
    cells_queued += cols * rows;
  endtask

  task automatic queue_cell(input logic [BYTE_W-1:0] cell_byte);
    pending_cells.push_back(cell_byte);
    cells_queued++;
  endtask

  // Waits until every queued cell is taken and every square has come back.
  task automatic wait_idle();
    while (cells_accepted != cells_queued || expected_squares.size() != 0)
      @(negedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(13, 20);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic int pick_obstacle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_density();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 100;
      2:       return $urandom_range(1, 10);
      3:       return $urandom_range(10, 30);
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  // Cell driver: presents the next pending cell after its drawn gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || cell_taken) begin
      if (send_wait != 0) begin
        in_valid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_cells.size() != 0) begin
        in_valid     <= 1'b1;
        in_cell_byte <= pending_cells.pop_front();
        send_wait    <= send_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls per result, plus one long hold on request.
  always @(negedge clk) begin : result_sink
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (long_hold_req && !long_hold_begun) begin
      long_hold_begun <= 1'b1;
      hold_left       <= LONG_HOLD;
      out_ready       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (result_taken) begin
      draw = recv_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
      recv_wait <= draw;
      out_ready <= (draw == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checker: compares each result request with the oldest predicted square,
  // then feeds the accepted cell to the predictor.
  always @(posedge clk) begin : result_check
    square_t want;
    cycle_count++;
    cell_taken   <= in_valid && in_ready;
    result_taken <= out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_squares.size() == 0) begin
          $error("Unexpected result: best_size %0d top_row %0d left_col %0d",
                 out_best_size, out_top_row, out_left_col);
          mismatches++;
        end else begin
          want = expected_squares.pop_front();
          if (out_best_size !== want.size) begin
            $error("best_size: expected %0d, got %0d", want.size, out_best_size);
            mismatches++;
          end
          if (out_top_row !== want.row) begin
            $error("top_row: expected %0d, got %0d", want.row, out_top_row);
            mismatches++;
          end
          if (out_left_col !== want.col) begin
            $error("left_col: expected %0d, got %0d", want.col, out_left_col);
            mismatches++;
          end
          squares_checked++;
        end
      end
      if (in_valid && in_ready) begin
        scan_cell(in_cell_byte);
        cells_accepted++;
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d squares outstanding.",
               cycle_count, expected_squares.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int big_start;
    clear_scan();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Single-cell maps from zero lengths: an obstacle, then the lowest byte.
    configure(255, 0, 0);
    queue_cell(8'd255);
    queue_cell(8'd0);
    wait_idle();

    // Obstacle byte zero, and a fully open 3x3 map of the highest byte.
    configure(0, 3, 3);
    repeat (9) queue_cell(8'd255);
    wait_idle();

    // Two equal, overlapping 2x2 squares: the leftmost must win.
    configure(0, 3, 2);
    repeat (6) queue_cell(8'h5A);
    wait_idle();

    // A write past the last register must leave the setting alone.
    write_register(UNUSED_REG_IDX, '1);
    queue_map(20);
    wait_idle();

    // A row length above the maximum clamps to a full row.
    configure(pick_obstacle(), 2047, 1);
    queue_map(95);
    wait_idle();

    // Back-pressure: tiny maps while the sink holds off for a long stretch.
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    configure(pick_obstacle(), 2, 1);
    @(posedge clk);
    long_hold_req = 1'b1;
    repeat (60) queue_map($urandom_range(0, 100));
    wait_idle();

    // Random settings, one to four maps each, with idling switched per phase.
    big_start = cells_queued;
    while (cells_queued - big_start < SMALL_CELL_BUDGET) begin
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      configure(pick_obstacle(), pick_length(), pick_length());
      repeat ($urandom_range(1, 4)) queue_map(pick_density());
      wait_idle();
    end

    repeat (END_DRAIN) @(negedge clk);
    $display("Checked %0d squares from %0d cells over %0d register settings.",
             squares_checked, cells_accepted, settings_used);
    $display("Covered single cells, clamped lengths, ties, edge obstacle bytes and a long stall.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
